[hdl/assert_macros.svh]
// Assertion macros shared by the queue RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SFQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/sfq_pkg.sv]
// Package for the searchable FIFO/LIFO queue: operation, status, state
// codes, cell control struct and default sizes. No dependencies.
`default_nettype none

package sfq_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_WORD_WIDTH  = 32;

  localparam int VALUE_W   = 32;
  localparam int OCC_W     = 7;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;
  localparam int TUSER_W   = 2;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_TAKE = 2'd1,
    OP_YANK = 2'd2,
    OP_FIND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_PREFIX,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic cmp;
    logic shr;
    logic shl_all;
    logic yank;
    logic put_tail;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/searchable_fifo_lifo_queue_top.sv]
// Searchable FIFO/LIFO queue, top level: request FSM, row of cells, prefix.
// Depends on sfq_pkg, sfq_cell, sfq_prefix and assert_macros.svh.
//
// Requests enter on s_* (s_tuser = operation, s_tdata = value); one result
// per request leaves on m_* (m_tdata = data and occupancy, m_tuser = status).
// Operations: put, take from head, remove first match, contains query.
// cfg_wen/cfg_wdata write the queue mode (0 FIFO put at tail, 1 LIFO put at
// head); write it only while no request is in flight.
// Each request passes through accept, compare in every cell, prefix OR of
// the match flags, then the shift in the cell row with the result written
// to the output register. No new request is accepted until the previous
// one has been applied and the FSM is back in idle.
// If the receiver stalls, the result is held in the output register and the
// next request waits in its apply cycle until the register frees up.
// Reset (synchronous, rst high) empties the queue, sets FIFO mode and drops
// any pending result; stored words are left as they are.
`default_nettype none

module searchable_fifo_lifo_queue_top import sfq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int WORD_WIDTH  = DEF_WORD_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
  input  wire logic [TUSER_W-1:0]   s_tuser,   // [1:0] operation
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata,   // [31:0] data, [38:32] occupancy, zero pad
  output logic      [TUSER_W-1:0]   m_tuser,   // [1:0] status
  input  wire logic                 cfg_wen,
  input  wire logic                 cfg_wdata
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t                state;
  state_t                state_next;
  op_t                   req_op;
  logic [WORD_WIDTH-1:0] req_word;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  queue_mode;
  cell_ctl_t             ctl;
  logic                  out_load;
  logic [WORD_WIDTH-1:0] res_data;
  status_t               res_status;
  logic [63:0]           value_ext;
  logic [63:0]           res_ext;

  logic [WORD_WIDTH-1:0]  cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] incl;
  logic                   found;

  assign value_ext = 64'(s_tdata);
  assign res_ext   = 64'(res_data);
  assign found     = incl[QUEUE_DEPTH-1];
  assign s_tready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_mode <= 1'b0;
    end else if (cfg_wen) begin
      queue_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_op   <= op_t'(s_tuser);
      req_word <= value_ext[WORD_WIDTH-1:0];
    end
    if (out_load) begin
      m_tdata <= M_TDATA_W'({OCC_W'(count_next), res_ext[VALUE_W-1:0]});
      m_tuser <= res_status;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ctl        = '0;
    out_load   = 1'b0;
    res_data   = '0;
    res_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        ctl.cmp    = 1'b1;
        state_next = S_PREFIX;
      end
      S_PREFIX: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          case (req_op)
            OP_PUT: begin
              if (count == CNT_W'(QUEUE_DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                ctl.shr      = queue_mode;
                ctl.put_tail = !queue_mode;
                count_next   = count + CNT_W'(1);
              end
            end
            OP_TAKE: begin
              if (count == '0) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.shl_all = 1'b1;
                res_data    = cell_entry[0];
                count_next  = count - CNT_W'(1);
              end
            end
            OP_YANK: begin
              if (!found) begin
                res_status = ST_NOTFOUND;
              end else begin
                ctl.yank   = 1'b1;
                res_data   = req_word;
                count_next = count - CNT_W'(1);
              end
            end
            default: begin
              if (!found) begin
                res_status = ST_NOTFOUND;
              end
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left;
    logic [WORD_WIDTH-1:0] right;

    if (i == 0) begin : g_head
      assign left = req_word;
    end else begin : g_body
      assign left = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = cell_entry[i];
    end else begin : g_inner
      assign right = cell_entry[i+1];
    end

    sfq_cell #(
      .IDX        (i),
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .word  (req_word),
      .count (count),
      .left  (left),
      .right (right),
      .incl  (incl[i]),
      .entry (cell_entry[i]),
      .match (match[i])
    );
  end

  sfq_prefix #(
    .DEPTH (QUEUE_DEPTH)
  ) u_prefix (
    .clk   (clk),
    .rst   (rst),
    .match (match),
    .incl  (incl)
  );

  `SFQ_ASSERT(a_cnt_max, (count <= CNT_W'(QUEUE_DEPTH)), "entry count above depth")
  `SFQ_ASSERT_NEXT(a_accept_match, (s_tvalid && s_tready), (state == S_MATCH), "request not compared")
  `SFQ_ASSERT_NEXT(a_cnt_hold, (state != S_APPLY), $stable(count), "count moved outside apply")
  `SFQ_ASSERT_NEXT(a_result_load, (state == S_APPLY && (!m_tvalid || m_tready)), (m_tvalid && state == S_IDLE), "result not loaded")

endmodule

`default_nettype wire

[hdl/sfq_cell.sv]
// One queue position: holds a word, shifts with its neighbors and
// registers its own compare against the request word. Uses sfq_pkg.
`default_nettype none

module sfq_cell import sfq_pkg::*; #(
  parameter int IDX        = 0,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int CNT_W      = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_ctl_t             ctl,
  input  wire logic [WORD_WIDTH-1:0] word,
  input  wire logic [CNT_W-1:0]      count,
  input  wire logic [WORD_WIDTH-1:0] left,
  input  wire logic [WORD_WIDTH-1:0] right,
  input  wire logic                  incl,
  output logic      [WORD_WIDTH-1:0] entry,
  output logic                       match
);

  logic live;
  logic tail;

  assign live = CNT_W'(IDX) < count;
  assign tail = CNT_W'(IDX) == count;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.cmp) begin
      match <= live && (entry == word);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shr) begin
      entry <= left;
    end else if (ctl.shl_all || (ctl.yank && incl)) begin
      entry <= right;
    end else if (ctl.put_tail && tail) begin
      entry <= word;
    end
  end

endmodule

`default_nettype wire

[hdl/sfq_prefix.sv]
// Registered parallel-prefix OR over the cell match flags: bit i is set
// when some cell at or before position i matched. Uses sfq_pkg.
`default_nettype none

module sfq_prefix import sfq_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [DEPTH-1:0] match,
  output logic      [DEPTH-1:0] incl
);

  `include "assert_macros.svh"

  localparam int LEVELS = $clog2(DEPTH);

  logic [DEPTH-1:0] lv [LEVELS+1];

  always_comb begin
    lv[0] = match;
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << l)) begin
          lv[l+1][i] = lv[l][i] | lv[l][i-(1<<l)];
        end else begin
          lv[l+1][i] = lv[l][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      incl <= '0;
    end else begin
      incl <= lv[LEVELS];
    end
  end

  `SFQ_ASSERT(a_incl_mono, (((incl << 1) & ~incl) == '0), "prefix flags not monotonic")
  `SFQ_ASSERT_NEXT(a_incl_zero, (match == '0), (incl == '0), "prefix set without any match")

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking bench for searchable_fifo_lifo_queue_top: queue-based driver,
// result monitor and a software queue predictor.
// Depends on sfq_pkg and the queue RTL in hdl/.
`default_nettype none

module testbench;
  import sfq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;

  typedef struct {
    op_t         op;
    logic [31:0] value;
  } request_t;

  typedef struct {
    logic [31:0] data;
    status_t     status;
    logic [6:0]  occupancy;
  } outcome_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [TUSER_W-1:0]   s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [TUSER_W-1:0]   m_tuser;
  logic                 cfg_wen = 1'b0;
  logic                 cfg_wdata = 1'b0;

  request_t    pending_requests[$];
  outcome_t    due_results[$];
  logic [31:0] held_words[$];
  bit          lifo_mode;
  int          mismatches;
  int          src_gap, sink_gap, idle_cycles;
  bit          src_calm, sink_calm;

  searchable_fifo_lifo_queue_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Queue predictor: head is index 0.
  function automatic outcome_t apply_request(request_t rq);
    outcome_t res;
    int hit;
    res.data = '0;
    res.status = ST_OK;
    hit = -1;
    case (rq.op)
      OP_PUT: begin
        if (held_words.size() >= DEF_QUEUE_DEPTH) res.status = ST_FULL;
        else if (lifo_mode) held_words.push_front(rq.value);
        else held_words.push_back(rq.value);
      end
      OP_TAKE: begin
        if (held_words.size() == 0) res.status = ST_EMPTY;
        else res.data = held_words.pop_front();
      end
      default: begin
        foreach (held_words[i])
          if (hit < 0 && held_words[i] == rq.value) hit = i;
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else if (rq.op == OP_YANK) begin
          res.data = held_words[hit];
          held_words.delete(hit);
        end
      end
    endcase
    res.occupancy = 7'(held_words.size());
    return res;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = $urandom_range(0, 9);
    end else begin
      if (!(s_tvalid && !s_tready)) begin
        if (s_tvalid) begin
          due_results.push_back(apply_request(pending_requests.pop_front()));
          if ($urandom_range(0, 40) == 0) src_calm = !src_calm;
          src_gap = src_calm ? 0 : $urandom_range(0, 9);
        end
        if (src_gap > 0 || pending_requests.size() == 0) begin
          if (src_gap > 0) src_gap--;
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_requests[0].value;
          s_tuser  <= pending_requests[0].op;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = $urandom_range(0, 9);
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: data=%h status=%0d occupancy=%0d",
                     m_tdata[31:0], m_tuser, m_tdata[38:32]);
        end else begin
          want = due_results.pop_front();
          if (m_tdata[31:0] !== want.data || m_tuser !== want.status ||
              m_tdata[38:32] !== want.occupancy) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected data=%h status=%0d occupancy=%0d,",
                        " got data=%h status=%0d occupancy=%0d"},
                       want.data, want.status, want.occupancy,
                       m_tdata[31:0], m_tuser, m_tdata[38:32]);
          end
        end
        if ($urandom_range(0, 40) == 0) sink_calm = !sink_calm;
        sink_gap = sink_calm ? 0 : $urandom_range(0, 9);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any request or result moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(op_t op, logic [31:0] value);
    request_t rq;
    rq.op = op;
    rq.value = value;
    pending_requests.push_back(rq);
  endtask

  task automatic drain_and_settle();
    while (pending_requests.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(bit lifo);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= lifo;
    lifo_mode = lifo;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Segments alternate between filling, draining and mixed traffic so the
  // queue swings between empty and full; values mostly come from a small
  // pool so removes and lookups hit, including duplicates.
  task automatic queue_random(int count);
    logic [31:0] pool[8];
    logic [31:0] value;
    int n, tilt, tilt_left, roll;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    tilt = 0;
    tilt_left = 0;
    for (n = 0; n < count; n++) begin
      if (tilt_left == 0) begin
        tilt = $urandom_range(0, 2);
        tilt_left = $urandom_range(30, 100);
      end
      tilt_left--;
      roll = $urandom_range(0, 99);
      value = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 7)];
      case (tilt)
        0: begin
          if (roll < 85) send(OP_PUT, value);
          else if (roll < 92) send(OP_TAKE, value);
          else if (roll < 96) send(OP_YANK, value);
          else send(OP_FIND, value);
        end
        1: begin
          if (roll < 10) send(OP_PUT, value);
          else if (roll < 55) send(OP_TAKE, value);
          else if (roll < 85) send(OP_YANK, value);
          else send(OP_FIND, value);
        end
        default: begin
          if (roll < 35) send(OP_PUT, value);
          else if (roll < 55) send(OP_TAKE, value);
          else if (roll < 80) send(OP_YANK, value);
          else send(OP_FIND, value);
        end
      endcase
    end
  endtask

  initial begin
    int ph;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // empty queue corner cases
    send(OP_TAKE, 32'h0000_0000);
    send(OP_YANK, 32'h0000_0000);
    send(OP_FIND, 32'h0000_0000);
    // FIFO order, duplicates, first match removal
    send(OP_PUT, 32'h0000_0000);
    send(OP_PUT, 32'hFFFF_FFFF);
    send(OP_PUT, 32'h5A5A_5A5A);
    send(OP_PUT, 32'hFFFF_FFFF);
    send(OP_FIND, 32'hFFFF_FFFF);
    send(OP_FIND, 32'h1234_5678);
    send(OP_YANK, 32'hFFFF_FFFF);
    send(OP_YANK, 32'h1234_5678);
    send(OP_TAKE, 32'hFFFF_FFFF);
    send(OP_TAKE, 32'h0000_0000);
    send(OP_TAKE, 32'hFFFF_FFFF);
    send(OP_TAKE, 32'h0000_0000);
    drain_and_settle();

    // LIFO insertion at head
    write_mode(1'b1);
    send(OP_PUT, 32'hA5A5_A5A5);
    send(OP_PUT, 32'h0000_0001);
    send(OP_PUT, 32'h8000_0000);
    send(OP_TAKE, 32'h0000_0000);
    send(OP_YANK, 32'hA5A5_A5A5);
    send(OP_TAKE, 32'h0000_0000);
    send(OP_TAKE, 32'h0000_0000);
    drain_and_settle();

    for (ph = 0; ph < 4; ph++) begin
      write_mode(ph[0] == 1'b0);
      queue_random(285);
      drain_and_settle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[searchable_fifo_lifo_queue_top.f]
+incdir+hdl
hdl/sfq_pkg.sv
hdl/sfq_cell.sv
hdl/sfq_prefix.sv
hdl/searchable_fifo_lifo_queue_top.sv
sim/testbench.sv
